// ===== design/csts_pkg.sv =====
// ----------------------------------------------------------------------------
// csts_pkg: shared types and constants of the token scanner
// Token kinds, error codes, byte classes and the keyword lookup.
// ----------------------------------------------------------------------------
package csts_pkg;

   localparam int OUT_BITS = 20;
   localparam int KW_CHARS = 8;

   localparam logic [5:0] KIND_END      = 6'd0;
   localparam logic [5:0] KIND_IDENT    = 6'd1;
   localparam logic [5:0] KIND_INT      = 6'd2;
   localparam logic [5:0] KIND_FLOAT    = 6'd3;
   localparam logic [5:0] KIND_STRING   = 6'd4;
   localparam logic [5:0] KIND_KW_BASE  = 6'd5;
   localparam logic [5:0] KIND_AND      = 6'd17;
   localparam logic [5:0] KIND_OR       = 6'd18;
   localparam logic [5:0] KIND_LE       = 6'd19;
   localparam logic [5:0] KIND_GE       = 6'd20;
   localparam logic [5:0] KIND_EQ       = 6'd21;
   localparam logic [5:0] KIND_NE       = 6'd22;
   localparam logic [5:0] KIND_PLUS     = 6'd23;
   localparam logic [5:0] KIND_MINUS    = 6'd24;
   localparam logic [5:0] KIND_MUL      = 6'd25;
   localparam logic [5:0] KIND_DIV      = 6'd26;
   localparam logic [5:0] KIND_MOD      = 6'd27;
   localparam logic [5:0] KIND_NOT      = 6'd28;
   localparam logic [5:0] KIND_LT       = 6'd29;
   localparam logic [5:0] KIND_GT       = 6'd30;
   localparam logic [5:0] KIND_ASSIGN   = 6'd31;
   localparam logic [5:0] KIND_SEMI     = 6'd32;
   localparam logic [5:0] KIND_COMMA    = 6'd33;
   localparam logic [5:0] KIND_LPAREN   = 6'd34;
   localparam logic [5:0] KIND_RPAREN   = 6'd35;
   localparam logic [5:0] KIND_LBRACKET = 6'd36;
   localparam logic [5:0] KIND_RBRACKET = 6'd37;
   localparam logic [5:0] KIND_LBRACE   = 6'd38;
   localparam logic [5:0] KIND_RBRACE   = 6'd39;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_COMMENT  = 3'd1;
   localparam logic [2:0] ERR_STRING   = 3'd2;
   localparam logic [2:0] ERR_NEWLINE  = 3'd3;
   localparam logic [2:0] ERR_ESCAPE   = 3'd4;
   localparam logic [2:0] ERR_BAD_CHAR = 3'd5;
   localparam logic [2:0] ERR_OVERFLOW = 3'd6;

   typedef struct packed {
      logic [5:0]          token_kind;
      logic [OUT_BITS-1:0] token_start;
      logic [OUT_BITS-1:0] token_length;
      logic [OUT_BITS-1:0] token_line;
      logic [2:0]          error_code;
      logic                last_result;
   } tok_type;

   typedef struct packed {
      logic    v0;
      logic    v1;
      tok_type tok0;
      tok_type tok1;
   } push_type;

   typedef logic [7:0] byte_type;

   localparam logic [63:0] KW_TEXT [12] = '{
      64'("const"), 64'("int"), 64'("float"), 64'("void"), 64'("if"), 64'("else"),
      64'("while"), 64'("break"), 64'("continue"), 64'("return"), 64'("getint"),
      64'("printf")};
   localparam logic [3:0] KW_LEN [12] = '{4'd5, 4'd3, 4'd5, 4'd4, 4'd2, 4'd4,
                                          4'd5, 4'd5, 4'd8, 4'd6, 4'd6, 4'd6};

   function automatic logic is_alpha(byte_type c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_digit(byte_type c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_oct(byte_type c);
      return c >= "0" && c <= "7";
   endfunction

   function automatic logic is_xdigit(byte_type c);
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic [5:0] single_op(byte_type c);
      logic [5:0] k;
      case (c)
         "+": k = KIND_PLUS;
         "-": k = KIND_MINUS;
         "*": k = KIND_MUL;
         "%": k = KIND_MOD;
         ";": k = KIND_SEMI;
         ",": k = KIND_COMMA;
         "(": k = KIND_LPAREN;
         ")": k = KIND_RPAREN;
         "[": k = KIND_LBRACKET;
         "]": k = KIND_RBRACKET;
         "{": k = KIND_LBRACE;
         "}": k = KIND_RBRACE;
         default: k = KIND_END;
      endcase
      return k;
   endfunction

   // buffer packed as the first count bytes, right aligned like a string literal
   function automatic logic [5:0] ident_kind(logic [63:0] word, logic [3:0] count);
      logic [5:0] k;
      k = KIND_IDENT;
      if (count <= 4'(KW_CHARS)) begin
         for (int i = 0; i < 12; i++) begin
            if (KW_LEN[i] == count && KW_TEXT[i] == word) k = KIND_KW_BASE + 6'(i);
         end
      end
      return k;
   endfunction

endpackage

// ===== design/csts_chan_if.sv =====
// ----------------------------------------------------------------------------
// csts_req_if / csts_rsp_if: valid/ready channels of the token scanner
// Source bytes in, tokens out.
// ----------------------------------------------------------------------------
interface csts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_source;
   modport source (output valid, char_byte, end_of_source, input ready);
   modport sink   (input valid, char_byte, end_of_source, output ready);
endinterface

interface csts_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  token_kind;
   logic [19:0] token_start;
   logic [19:0] token_length;
   logic [19:0] token_line;
   logic [2:0]  error_code;
   logic        last_result;
   modport source (output valid, token_kind, token_start, token_length, token_line,
                   error_code, last_result, input ready);
   modport sink   (input valid, token_kind, token_start, token_length, token_line,
                   error_code, last_result, output ready);
endinterface

// ===== design/csts_front.sv =====
// ----------------------------------------------------------------------------
// csts_front: scanner state machine
// Classifies one accepted byte a cycle and produces up to two tokens per beat.
// ----------------------------------------------------------------------------
module csts_front #(
   parameter int POSITION_BITS = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          char_byte,
   input  logic                end_of_source,
   output csts_pkg::push_type  push
);

   localparam int EW = POSITION_BITS + csts_pkg::OUT_BITS;

   typedef enum logic [4:0] {
      M_IDLE, M_IDENT, M_SLASH, M_LINE, M_BLOCK, M_BSTAR, M_STR, M_ESC, M_LT, M_GT,
      M_ASG, M_NOT, M_AMP, M_BAR, M_DOT, M_DEC, M_ZERO, M_OCT, M_FRAC, M_EXPS,
      M_EXPD, M_HEX, M_HEXF
   } mode_type;

   mode_type                 mode_ff, mode_in;
   logic [19:0]              line_ff, line_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in, tb_ff, tb_in, off;
   logic [7:0]               buf_ff [csts_pkg::KW_CHARS];
   logic [7:0]               buf_in [csts_pkg::KW_CHARS];
   logic [3:0]               wc_ff, wc_in;
   logic                     halt_ff, halt_in;
   csts_pkg::tok_type        res [2];
   logic [1:0]               cnt;
   logic                     redo;
   logic [63:0]              word;
   logic [5:0]               fkind;
   logic                     fvalid;
   logic [7:0]               c;

   function automatic logic [19:0] narrow(logic [POSITION_BITS-1:0] x);
      logic [EW-1:0] w;
      w = EW'(x);
      return w[19:0];
   endfunction

   function automatic csts_pkg::tok_type mk(logic [5:0] k, logic [POSITION_BITS-1:0] s,
                                            logic [POSITION_BITS-1:0] l, logic [2:0] e,
                                            logic last, logic [19:0] ln);
      csts_pkg::tok_type t;
      t.token_kind   = k;
      t.token_start  = narrow(s);
      t.token_length = narrow(l);
      t.token_line   = ln;
      t.error_code   = e;
      t.last_result  = last;
      return t;
   endfunction

   always_comb begin
      word = '0;
      for (int j = 0; j < csts_pkg::KW_CHARS; j++) begin
         if (4'(j) < wc_ff) word = {word[55:0], buf_ff[j]};
      end
   end

   always_comb begin
      fvalid = 1'b1;
      case (mode_ff)
         M_IDENT: fkind = csts_pkg::ident_kind(word, wc_ff);
         M_SLASH: fkind = csts_pkg::KIND_DIV;
         M_LT:    fkind = csts_pkg::KIND_LT;
         M_GT:    fkind = csts_pkg::KIND_GT;
         M_ASG:   fkind = csts_pkg::KIND_ASSIGN;
         M_NOT:   fkind = csts_pkg::KIND_NOT;
         M_DEC, M_ZERO, M_OCT, M_HEX: fkind = csts_pkg::KIND_INT;
         M_FRAC, M_EXPS, M_EXPD, M_HEXF: fkind = csts_pkg::KIND_FLOAT;
         default: begin
            fkind  = csts_pkg::KIND_END;
            fvalid = 1'b0;
         end
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      line_in = line_ff;
      pos_in  = pos_ff;
      tb_in   = tb_ff;
      wc_in   = wc_ff;
      halt_in = halt_ff;
      buf_in  = buf_ff;
      res[0]  = '0;
      res[1]  = '0;
      cnt     = '0;
      redo    = 1'b0;
      off     = pos_ff;
      c       = char_byte;
      if (accept && end_of_source) begin
         if (!halt_ff) begin
            case (mode_ff)
               M_BLOCK, M_BSTAR: begin
                  res[0] = mk(csts_pkg::KIND_END, tb_ff, '0, csts_pkg::ERR_COMMENT, 1'b1, line_ff);
                  cnt = 2'd1;
               end
               M_STR: begin
                  res[0] = mk(csts_pkg::KIND_END, tb_ff, '0, csts_pkg::ERR_STRING, 1'b1, line_ff);
                  cnt = 2'd1;
               end
               M_ESC: begin
                  res[0] = mk(csts_pkg::KIND_END, tb_ff, '0, csts_pkg::ERR_ESCAPE, 1'b1, line_ff);
                  cnt = 2'd1;
               end
               M_AMP, M_BAR, M_DOT: begin
                  res[0] = mk(csts_pkg::KIND_END, tb_ff, '0, csts_pkg::ERR_BAD_CHAR, 1'b1,
                              line_ff);
                  cnt = 2'd1;
               end
               default: begin
                  if (fvalid) begin
                     res[0] = mk(fkind, tb_ff, pos_ff - tb_ff, csts_pkg::ERR_NONE, 1'b0, line_ff);
                     cnt = 2'd1;
                  end
                  res[cnt[0]] = mk(csts_pkg::KIND_END, pos_ff, '0, csts_pkg::ERR_NONE, 1'b1,
                                   line_ff);
                  cnt = cnt + 2'd1;
               end
            endcase
         end
         mode_in = M_IDLE;
         line_in = 20'd1;
         pos_in  = '0;
         tb_in   = '0;
         wc_in   = '0;
         halt_in = 1'b0;
      end else if (accept && !halt_ff) begin
         if (&pos_ff) begin
            res[0]  = mk(csts_pkg::KIND_END, off, '0, csts_pkg::ERR_OVERFLOW, 1'b1, line_ff);
            cnt     = 2'd1;
            halt_in = 1'b1;
            mode_in = M_IDLE;
         end else begin
            case (mode_ff)
               M_IDENT: begin
                  if (csts_pkg::is_alpha(c) || csts_pkg::is_digit(c)) begin
                     if (wc_ff < 4'(csts_pkg::KW_CHARS)) begin
                        buf_in[wc_ff[2:0]] = c;
                        wc_in = wc_ff + 4'd1;
                     end else begin
                        wc_in = 4'(csts_pkg::KW_CHARS + 1);
                     end
                  end else redo = 1'b1;
               end
               M_SLASH: begin
                  if (c == "/") mode_in = M_LINE;
                  else if (c == "*") mode_in = M_BLOCK;
                  else redo = 1'b1;
               end
               M_LINE: begin
                  if (c == 8'h0A) begin
                     if (line_ff != '1) line_in = line_ff + 20'd1;
                     mode_in = M_IDLE;
                  end
               end
               M_BLOCK: begin
                  if (c == "*") mode_in = M_BSTAR;
                  else if (c == 8'h0A && line_ff != '1) line_in = line_ff + 20'd1;
               end
               M_BSTAR: begin
                  if (c == "/") mode_in = M_IDLE;
                  else if (c != "*") begin
                     if (c == 8'h0A && line_ff != '1) line_in = line_ff + 20'd1;
                     mode_in = M_BLOCK;
                  end
               end
               M_STR: begin
                  if (c == 8'h22) begin
                     mode_in = M_IDLE;
                     res[0]  = mk(csts_pkg::KIND_STRING, tb_ff, off + 1'b1 - tb_ff,
                                  csts_pkg::ERR_NONE, 1'b0, line_ff);
                     cnt     = 2'd1;
                  end else if (c == 8'h5C) begin
                     mode_in = M_ESC;
                  end else if (c == 8'h0A) begin
                     res[0]  = mk(csts_pkg::KIND_END, tb_ff, '0, csts_pkg::ERR_NEWLINE, 1'b1,
                                  line_ff);
                     cnt     = 2'd1;
                     halt_in = 1'b1;
                     mode_in = M_IDLE;
                  end
               end
               M_ESC: mode_in = M_STR;
               M_LT, M_GT, M_ASG, M_NOT: begin
                  if (c == "=") begin
                     mode_in = M_IDLE;
                     res[0]  = mk((mode_ff == M_LT) ? csts_pkg::KIND_LE :
                                  (mode_ff == M_GT) ? csts_pkg::KIND_GE :
                                  (mode_ff == M_ASG) ? csts_pkg::KIND_EQ : csts_pkg::KIND_NE,
                                  tb_ff, POSITION_BITS'(2), csts_pkg::ERR_NONE, 1'b0, line_ff);
                     cnt     = 2'd1;
                  end else redo = 1'b1;
               end
               M_AMP, M_BAR: begin
                  mode_in = M_IDLE;
                  cnt     = 2'd1;
                  if ((mode_ff == M_AMP && c == "&") || (mode_ff == M_BAR && c == "|")) begin
                     res[0] = mk((mode_ff == M_AMP) ? csts_pkg::KIND_AND : csts_pkg::KIND_OR,
                                 tb_ff, POSITION_BITS'(2), csts_pkg::ERR_NONE, 1'b0, line_ff);
                  end else begin
                     res[0]  = mk(csts_pkg::KIND_END, tb_ff, '0, csts_pkg::ERR_BAD_CHAR, 1'b1,
                                  line_ff);
                     halt_in = 1'b1;
                  end
               end
               M_DOT: begin
                  if (csts_pkg::is_digit(c)) mode_in = M_FRAC;
                  else begin
                     res[0]  = mk(csts_pkg::KIND_END, tb_ff, '0, csts_pkg::ERR_BAD_CHAR, 1'b1,
                                  line_ff);
                     cnt     = 2'd1;
                     halt_in = 1'b1;
                     mode_in = M_IDLE;
                  end
               end
               M_DEC, M_ZERO, M_OCT: begin
                  if (mode_ff == M_ZERO && (c == "x" || c == "X")) mode_in = M_HEX;
                  else if (mode_ff == M_DEC && csts_pkg::is_digit(c)) mode_in = M_DEC;
                  else if (mode_ff != M_DEC && csts_pkg::is_oct(c)) mode_in = M_OCT;
                  else if (c == ".") mode_in = M_FRAC;
                  else if (c == "e" || c == "E") mode_in = M_EXPS;
                  else redo = 1'b1;
               end
               M_FRAC: begin
                  if (c == "e" || c == "E") mode_in = M_EXPS;
                  else if (!csts_pkg::is_digit(c)) redo = 1'b1;
               end
               M_EXPS: begin
                  if (c == "+" || c == "-" || csts_pkg::is_digit(c)) mode_in = M_EXPD;
                  else redo = 1'b1;
               end
               M_EXPD: begin
                  if (!csts_pkg::is_digit(c)) redo = 1'b1;
               end
               M_HEX, M_HEXF: begin
                  if (csts_pkg::is_xdigit(c)) mode_in = mode_ff;
                  else if (c == "." && mode_ff == M_HEX) mode_in = M_HEXF;
                  else if (c == "p" || c == "P") mode_in = M_EXPS;
                  else redo = 1'b1;
               end
               default: redo = 1'b1;
            endcase
            if (redo) begin
               if (fvalid) begin
                  res[0] = mk(fkind, tb_ff, off - tb_ff, csts_pkg::ERR_NONE, 1'b0, line_ff);
                  cnt    = 2'd1;
               end
               mode_in = M_IDLE;
               tb_in   = off;
               if (c == 8'h0A) begin
                  if (line_ff != '1) line_in = line_ff + 20'd1;
               end else if (c == " " || c == 8'h0D || c == 8'h09) begin
                  mode_in = M_IDLE;
               end else if (csts_pkg::is_alpha(c)) begin
                  mode_in   = M_IDENT;
                  buf_in[0] = c;
                  wc_in     = 4'd1;
               end else if (csts_pkg::is_digit(c)) begin
                  mode_in = (c == "0") ? M_ZERO : M_DEC;
               end else if (c == ".") mode_in = M_DOT;
               else if (c == 8'h22) mode_in = M_STR;
               else if (c == "/") mode_in = M_SLASH;
               else if (c == "<") mode_in = M_LT;
               else if (c == ">") mode_in = M_GT;
               else if (c == "=") mode_in = M_ASG;
               else if (c == "!") mode_in = M_NOT;
               else if (c == "&") mode_in = M_AMP;
               else if (c == "|") mode_in = M_BAR;
               else if (csts_pkg::single_op(c) != csts_pkg::KIND_END) begin
                  res[cnt[0]] = mk(csts_pkg::single_op(c), off, POSITION_BITS'(1),
                                   csts_pkg::ERR_NONE, 1'b0, line_ff);
                  cnt = cnt + 2'd1;
               end else begin
                  res[cnt[0]] = mk(csts_pkg::KIND_END, off, '0, csts_pkg::ERR_BAD_CHAR, 1'b1,
                                   line_ff);
                  cnt     = cnt + 2'd1;
                  halt_in = 1'b1;
               end
            end
            if (!halt_in) pos_in = off + 1'b1;
         end
      end
   end

   assign push.v0   = (cnt != 2'd0);
   assign push.v1   = cnt[1];
   assign push.tok0 = res[0];
   assign push.tok1 = res[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         line_ff <= 20'd1;
         pos_ff  <= '0;
         tb_ff   <= '0;
         wc_ff   <= '0;
         halt_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         line_ff <= line_in;
         pos_ff  <= pos_in;
         tb_ff   <= tb_in;
         wc_ff   <= wc_in;
         halt_ff <= halt_in;
      end
      buf_ff <= buf_in;
   end

endmodule

// ===== design/csts_queue.sv =====
// ----------------------------------------------------------------------------
// csts_queue: token queue and output side
// Four entries, up to two written and one read per cycle.
// ----------------------------------------------------------------------------
module csts_queue (
   input  logic               clock,
   input  logic               reset,
   input  csts_pkg::push_type push,
   output logic               room,
   output logic               out_valid,
   input  logic               out_ready,
   output csts_pkg::tok_type  out_tok
);

   csts_pkg::tok_type mem_ff [4];
   logic [1:0]        wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0]        count_ff, count_in;
   logic              pop;

   assign room      = (count_ff <= 3'd2);
   assign out_valid = (count_ff != 3'd0);
   assign out_tok   = mem_ff[rd_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in    = wr_ff + 2'(push.v0) + 2'(push.v1);
      rd_in    = rd_ff + 2'(pop);
      count_in = count_ff + 3'(push.v0) + 3'(push.v1) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push.v0) mem_ff[wr_ff] <= push.tok0;
      if (push.v1) mem_ff[wr_ff + 2'd1] <= push.tok1;
   end

endmodule

// ===== design/c_subset_token_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// c_subset_token_scanner_unit: streaming lexer for a small C subset
//
//   port      dir  beat
//   req_bus   in   one source byte, or end of source
//   rsp_bus   out  one token or error
//
// One byte a cycle; the scanner state machine settles each byte in the cycle
// it is taken. Up to two tokens per beat go into a four-entry queue, first
// token visible on rsp_bus the cycle after when the queue was empty. Input
// stalls only while the queue has fewer than two free entries. Reset is
// synchronous; it clears the scanner state and queue pointers, not storage.
// ----------------------------------------------------------------------------
module c_subset_token_scanner_unit #(
   parameter int POSITION_BITS = 20
) (
   input  logic              clock,
   input  logic              reset,
   csts_req_if.sink          req_bus,
   csts_rsp_if.source        rsp_bus
);

   csts_pkg::push_type push;
   csts_pkg::tok_type  out_tok;
   logic               room;
   logic               accept;

   assign req_bus.ready = room;
   assign accept        = req_bus.valid && room;

   csts_front #(.POSITION_BITS(POSITION_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .char_byte     (req_bus.char_byte),
      .end_of_source (req_bus.end_of_source),
      .push          (push)
   );

   csts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_tok   (out_tok)
   );

   assign rsp_bus.token_kind   = out_tok.token_kind;
   assign rsp_bus.token_start  = out_tok.token_start;
   assign rsp_bus.token_length = out_tok.token_length;
   assign rsp_bus.token_line   = out_tok.token_line;
   assign rsp_bus.error_code   = out_tok.error_code;
   assign rsp_bus.last_result  = out_tok.last_result;

   a_push_only_on_beat: assert property (@(posedge clock) disable iff (reset)
      push.v0 |-> accept) else $error("token without a beat");

   a_second_needs_first: assert property (@(posedge clock) disable iff (reset)
      push.v1 |-> push.v0) else $error("second token without first");

   a_error_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.error_code != csts_pkg::ERR_NONE |->
      rsp_bus.last_result && rsp_bus.token_kind == csts_pkg::KIND_END)
      else $error("error token not closing");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_bus.valid) else $error("output valid after reset");

endmodule
